// ===== rtl/core/dtfp_pkg.sv =====
// Package for the decimal text to fixed point block: word types, phase codes,
// character codes and limits. No dependencies; used by every file in rtl/core.
`timescale 1ns / 1ps

package dtfp_pkg;

  // input and result words
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               ok;
  } out_word_t;

  // parser phases
  localparam logic [1:0] PH_SIGN  = 2'd0;
  localparam logic [1:0] PH_WHOLE = 2'd1;
  localparam logic [1:0] PH_FRAC  = 2'd2;
  localparam logic [1:0] PH_FAIL  = 2'd3;

  // ASCII codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // fraction digits that reach the result
  localparam logic [1:0] FRAC_KEEP = 2'd3;

  // largest positive 64-bit value over 20: digit guard on the whole part
  localparam logic [62:0] WHOLE_GUARD = 63'd461168601842738790;
  // largest positive 64-bit value over 1000: largest whole part that scales
  // without saturating
  localparam logic [62:0] SCALE_LIMIT = 63'd9223372036854775;
  localparam logic [63:0] POS_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

  // finished string, handed from parser to scaler
  typedef struct packed {
    logic [62:0] whole;
    logic [9:0]  frac;
    logic [1:0]  cnt;
    logic        neg;
    logic        ok;
  } parse_res_t;

endpackage

// ===== rtl/core/decimal_text_to_fixed_point.sv =====
// Decimal text to fixed point, top level.
// One ASCII character per input word on the char channel; last flags the end
// of a string. An optional sign, a whole part (',' and '_' skipped), an
// optional '.' and fraction are parsed. On the last character one result word
// leaves on the res channel: value in thousandths (saturated, two's
// complement) and ok; a failed string gives value 0, ok 0.
// Both channels: a word moves on a clock edge with valid high and stall low.
// Throughput: one character per cycle, sustained, including back-to-back
// strings, while the scaler takes each last character; non-last characters
// never stall. A result word follows its last character through the input
// register, parser capture, x1000 scale, saturating add and sign/output
// register, in that order, and then shows on res_valid.
// When res_stall holds the output register, the pipeline fills behind it and
// char_stall rises only when a last character cannot move on.
// Reset (rst, synchronous) empties all stages and clears the parser state.
// Depends on dtfp_pkg, dtfp_parse, dtfp_scale.
`timescale 1ns / 1ps

module decimal_text_to_fixed_point (
  input  logic                clk,
  input  logic                rst,
  input  logic                char_valid,
  output logic                char_stall,
  input  dtfp_pkg::in_word_t  char_word,
  output logic                res_valid,
  input  logic                res_stall,
  output dtfp_pkg::out_word_t res_word
);
  import dtfp_pkg::*;

  in_word_t   s0_word;
  logic       s0_vld;
  logic       s0_take;
  logic       fin_ready;
  parse_res_t pres;

  // non-last words always drain; a last word waits for the scaler
  assign s0_take    = s0_vld && (!s0_word.last || fin_ready);
  assign char_stall = s0_vld && !s0_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (!char_stall) begin
      s0_vld <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) s0_word <= char_word;
  end

  dtfp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .take (s0_take),
    .word (s0_word),
    .res  (pres)
  );

  dtfp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_vld && s0_word.last),
    .in_res    (pres),
    .in_ready  (fin_ready),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_word.ok |-> res_word.value == 64'sd0)
    else $error("failed string with nonzero value");

  a_stall_last: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> s0_vld && s0_word.last)
    else $error("input stalled behind a non-last word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== rtl/core/dtfp_parse.sv =====
// Character parser: per-string state and its next-state logic.
// Depends on dtfp_pkg.
`timescale 1ns / 1ps

module dtfp_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  dtfp_pkg::in_word_t word,
  output dtfp_pkg::parse_res_t res
);
  import dtfp_pkg::*;

  logic [1:0]  phase;
  logic        negative;
  logic [62:0] whole_acc;
  logic [9:0]  frac_acc;
  logic [1:0]  frac_count;
  logic        seen_digit;

  logic [1:0]  phase_next;
  logic        negative_next;
  logic [62:0] whole_acc_next;
  logic [9:0]  frac_acc_next;
  logic [1:0]  frac_count_next;
  logic        seen_digit_next;
  logic        is_dig;
  logic        sign_done;
  logic [3:0]  dig;

  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    whole_acc_next  = whole_acc;
    frac_acc_next   = frac_acc;
    frac_count_next = frac_count;
    seen_digit_next = seen_digit;
    is_dig          = (word.ch inside {[CH_ZERO:CH_NINE]});
    dig             = word.ch[3:0];
    sign_done       = 1'b0;
    if (phase_next != PH_FAIL) begin
      if (phase_next == PH_SIGN) begin
        phase_next = PH_WHOLE;
        if (word.ch == CH_PLUS || word.ch == CH_MINUS) begin
          negative_next = (word.ch == CH_MINUS);
          sign_done     = 1'b1;
        end
      end
      if (!sign_done) begin
        if (phase_next == PH_WHOLE) begin
          if (is_dig) begin
            seen_digit_next = 1'b1;
            if (whole_acc > WHOLE_GUARD) begin
              phase_next = PH_FAIL;
            end else begin
              whole_acc_next = {whole_acc[59:0], 3'b000} + {whole_acc[61:0], 1'b0}
                             + {59'd0, dig};
            end
          end else if (word.ch == CH_COMMA || word.ch == CH_UNDER) begin
            phase_next = PH_WHOLE;
          end else if (word.ch == CH_DOT) begin
            phase_next = PH_FRAC;
          end else begin
            phase_next = PH_FAIL;
          end
        end else begin
          if (is_dig) begin
            seen_digit_next = 1'b1;
            // only the leading digits reach the result; the rest are dropped
            if (frac_count < FRAC_KEEP) begin
              frac_acc_next   = {frac_acc[6:0], 3'b000} + {frac_acc[8:0], 1'b0}
                              + {6'd0, dig};
              frac_count_next = frac_count + 2'd1;
            end
          end else begin
            phase_next = PH_FAIL;
          end
        end
      end
    end

    res.ok    = (phase_next != PH_FAIL) && seen_digit_next;
    res.whole = res.ok ? whole_acc_next : 63'd0;
    res.frac  = res.ok ? frac_acc_next : 10'd0;
    res.cnt   = res.ok ? frac_count_next : 2'd0;
    res.neg   = res.ok && negative_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && word.last)) begin
      phase      <= PH_SIGN;
      negative   <= 1'b0;
      whole_acc  <= 63'd0;
      frac_acc   <= 10'd0;
      frac_count <= 2'd0;
      seen_digit <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      negative   <= negative_next;
      whole_acc  <= whole_acc_next;
      frac_acc   <= frac_acc_next;
      frac_count <= frac_count_next;
      seen_digit <= seen_digit_next;
    end
  end

endmodule

// ===== rtl/core/dtfp_scale.sv =====
// Result pipeline: scales a finished string to thousandths, saturates,
// negates and holds the result word. Depends on dtfp_pkg.
`timescale 1ns / 1ps

module dtfp_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  dtfp_pkg::parse_res_t in_res,
  output logic                 in_ready,
  output logic                 res_valid,
  input  logic                 res_stall,
  output dtfp_pkg::out_word_t  res_word
);
  import dtfp_pkg::*;

  typedef struct packed {
    logic [63:0] raw;
    logic [9:0]  frac;
    logic        neg;
    logic        ok;
  } scaled_t;

  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic        ok;
  } summed_t;

  parse_res_t b_reg;
  scaled_t    c_reg;
  summed_t    d_reg;
  logic       b_vld, c_vld, d_vld;
  logic       out_rdy, d_rdy, c_rdy, b_rdy;

  scaled_t     c_next;
  summed_t     d_next;
  out_word_t   out_next;
  logic [63:0] w64;
  logic [63:0] prod;
  logic [63:0] sum;

  assign out_rdy  = !res_valid || !res_stall;
  assign d_rdy    = !d_vld || out_rdy;
  assign c_rdy    = !c_vld || d_rdy;
  assign b_rdy    = !b_vld || c_rdy;
  assign in_ready = b_rdy;

  // x1000 as x1024 - x16 - x8
  always_comb begin
    w64  = {1'b0, b_reg.whole};
    prod = (w64 << 10) - (w64 << 4) - (w64 << 3);
    c_next.raw = (b_reg.whole > SCALE_LIMIT) ? POS_MAX : prod;
    case (b_reg.cnt)
      2'd1:    c_next.frac = {b_reg.frac[3:0], 6'd0} + {b_reg.frac[4:0], 5'd0}
                           + {b_reg.frac[7:0], 2'd0};
      2'd2:    c_next.frac = {b_reg.frac[6:0], 3'd0} + {b_reg.frac[8:0], 1'b0};
      default: c_next.frac = b_reg.frac;
    endcase
    c_next.neg = b_reg.neg;
    c_next.ok  = b_reg.ok;
  end

  always_comb begin
    sum        = c_reg.raw + {54'd0, c_reg.frac};
    d_next.mag = sum[63] ? POS_MAX : sum;
    d_next.neg = c_reg.neg;
    d_next.ok  = c_reg.ok;
  end

  always_comb begin
    out_next.value = d_reg.neg ? $signed(~d_reg.mag + 64'd1) : $signed(d_reg.mag);
    out_next.ok    = d_reg.ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld     <= 1'b0;
      c_vld     <= 1'b0;
      d_vld     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (b_rdy) b_vld <= in_valid;
      if (c_rdy) c_vld <= b_vld;
      if (d_rdy) d_vld <= c_vld;
      if (out_rdy) res_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) b_reg <= in_res;
    if (c_rdy) c_reg <= c_next;
    if (d_rdy) d_reg <= d_next;
    if (out_rdy) res_word <= out_next;
  end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for decimal_text_to_fixed_point: a directed string table,
// then random, broken and noise strings, checked by typed results or parser model.
// Depends on dtfp_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_top;
  import dtfp_pkg::*;

  localparam int          KEEP_FRAC      = 6;     // fraction digits the model keeps
  localparam int          OUT_DIGITS     = 3;     // fraction digits in the result
  localparam logic [63:0] OUT_SCALE      = 64'd1000;
  localparam logic [7:0]  SPACE_CHAR     = 8'h20;
  localparam logic [7:0]  BYTE_MIN       = 8'h00;
  localparam logic [7:0]  BYTE_MAX       = 8'hFF;
  localparam int          RAND_CHARS     = 2000;
  localparam int          PAUSE_AT       = 1000;  // sender drains here
  localparam int          CALM_AT        = 1700;  // no idling from here on
  localparam int          HOLD_AT        = 800;   // receiver long hold-off
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 3000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_stall;
  in_word_t  char_word = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_word_t res_word;

  decimal_text_to_fixed_point dut (
    .clk(clk), .rst(rst),
    .char_valid(char_valid), .char_stall(char_stall), .char_word(char_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state
  logic [1:0]  ph = PH_SIGN;
  bit          is_neg = 1'b0;
  logic [63:0] whole_sum = '0;
  logic [19:0] frac_sum = '0;
  int          frac_digits = 0;
  bit          any_digit = 1'b0;

  out_word_t   parsed_numbers[$];
  logic [7:0]  text_buf[$];
  bit          idle_on = 1'b1;
  int          errors = 0;
  int          chars_seen = 0;
  int          stall_left = 0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;
  out_word_t   want;

  typedef struct {
    string              text;
    bit                 typed;
    logic signed [63:0] value;
    bit                 ok;
  } dir_row_t;

  // typed rows carry their result; the rest go through the model
  dir_row_t dir_table [26] = '{
    '{"0",                    1'b1,  64'sd0,          1'b1},
    '{"+",                    1'b1,  64'sd0,          1'b0},
    '{"-",                    1'b1,  64'sd0,          1'b0},
    '{".",                    1'b1,  64'sd0,          1'b0},
    '{"-.",                   1'b1,  64'sd0,          1'b0},
    '{".5",                   1'b1,  64'sd500,        1'b1},
    '{"5.",                   1'b1,  64'sd5000,       1'b1},
    '{"1.5",                  1'b1,  64'sd1500,       1'b1},
    '{"-2.25",                1'b1, -64'sd2250,       1'b1},
    '{"-0.000",               1'b1,  64'sd0,          1'b1},
    '{"+1_000,000",           1'b1,  64'sd1000000000, 1'b1},
    '{"_,7",                  1'b1,  64'sd7000,       1'b1},
    '{"1.2.3",                1'b1,  64'sd0,          1'b0},
    '{"--1",                  1'b1,  64'sd0,          1'b0},
    '{"1+2",                  1'b1,  64'sd0,          1'b0},
    '{"1._5",                 1'b1,  64'sd0,          1'b0},
    '{"12a",                  1'b1,  64'sd0,          1'b0},
    '{"\377",                 1'b1,  64'sd0,          1'b0},
    '{"0.1234567",            1'b0,  64'sd0,          1'b0},
    '{"0.0009",               1'b0,  64'sd0,          1'b0},
    '{"9223372036854775.807", 1'b0,  64'sd0,          1'b0},
    '{"9223372036854775.808", 1'b0,  64'sd0,          1'b0},
    '{"-9223372036854776",    1'b0,  64'sd0,          1'b0},
    '{"4611686018427387909",  1'b0,  64'sd0,          1'b0},
    '{"4611686018427387910",  1'b0,  64'sd0,          1'b0},
    '{"123456789.987654321",  1'b0,  64'sd0,          1'b0}
  };

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic add_char(input logic [7:0] c);
    text_buf.insert(text_buf.size(), c);
  endtask

  task automatic parse_char(input logic [7:0] c);
    if (ph == PH_FAIL) return;
    if (ph == PH_SIGN) begin
      ph = PH_WHOLE;
      if (c == CH_PLUS || c == CH_MINUS) begin
        is_neg = (c == CH_MINUS);
        return;
      end
    end
    if (ph == PH_WHOLE) begin
      if (is_digit(c)) begin
        any_digit = 1'b1;
        if (whole_sum > WHOLE_GUARD) ph = PH_FAIL;
        else whole_sum = whole_sum * 10 + (c - CH_ZERO);
      end else if (c == CH_DOT) begin
        ph = PH_FRAC;
      end else if (c != CH_COMMA && c != CH_UNDER) begin
        ph = PH_FAIL;
      end
    end else if (is_digit(c)) begin
      any_digit = 1'b1;
      if (frac_digits < KEEP_FRAC) begin
        frac_sum = 20'(frac_sum * 10 + (c - CH_ZERO));
        frac_digits++;
      end
    end else begin
      ph = PH_FAIL;
    end
  endtask

  // thousandths with saturation, then sign
  function automatic out_word_t finish_number();
    out_word_t   r;
    logic [63:0] frac;
    logic [63:0] raw;
    int          n;
    frac = 64'(frac_sum);
    n = frac_digits;
    while (n < OUT_DIGITS) begin
      frac = frac * 10;
      n++;
    end
    while (n > OUT_DIGITS) begin
      frac = frac / 10;
      n--;
    end
    if (whole_sum > POS_MAX / OUT_SCALE) raw = POS_MAX;
    else raw = whole_sum * OUT_SCALE;
    if (raw > POS_MAX - frac) raw = POS_MAX;
    else raw = raw + frac;
    r.value = is_neg ? -raw : raw;
    r.ok = 1'b1;
    if (ph == PH_FAIL || !any_digit) r = '0;
    return r;
  endfunction

  task automatic take_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    parse_char(w.ch);
    if (w.last) begin
      parsed_numbers.insert(parsed_numbers.size(), typed ? typed_res : finish_number());
      ph = PH_SIGN;
      is_neg = 1'b0;
      whole_sum = '0;
      frac_sum = '0;
      frac_digits = 0;
      any_digit = 1'b0;
    end
  endtask

  task automatic send_text(input bit typed, input out_word_t typed_res);
    in_word_t w;
    for (int i = 0; i < text_buf.size(); i++) begin
      w.ch = text_buf[i];
      w.last = (i == text_buf.size() - 1);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        char_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      char_valid <= 1'b1;
      char_word <= w;
      do @(posedge clk); while (char_stall);
      take_word(w, typed, typed_res);
    end
  endtask

  task automatic make_text();
    int          kind;
    int          pick;
    int          n;
    int          pos;
    string       prefix;
    logic [7:0]  bad;
    text_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      // noise bytes, extremes favored
      n = $urandom_range(1, 6);
      repeat (n) begin
        case ($urandom_range(0, 7))
          0:       add_char(BYTE_MIN);
          1:       add_char(BYTE_MAX);
          default: add_char(8'($urandom_range(0, 255)));
        endcase
      end
      return;
    end
    case ($urandom_range(0, 3))
      0:       add_char(CH_MINUS);
      1:       add_char(CH_PLUS);
      default: ;
    endcase
    // some whole parts sit near the digit guard or the scaling limit
    pick = $urandom_range(0, 19);
    if (pick == 0) prefix = "461168601842738";
    else if (pick == 1) prefix = "922337203685477";
    else prefix = "";
    for (int k = 0; k < prefix.len(); k++) add_char(prefix[k]);
    if (prefix.len() != 0) n = $urandom_range(1, 5);
    else if (pick < 4) n = $urandom_range(15, 21);
    else n = $urandom_range(0, 6);
    for (int k = 0; k < n; k++) begin
      if (k != 0 && $urandom_range(0, 9) == 0)
        add_char($urandom_range(0, 1) ? CH_COMMA : CH_UNDER);
      add_char(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) < 6) begin
      add_char(CH_DOT);
      n = $urandom_range(0, 9);
      repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if (text_buf.size() == 0) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
    if (kind >= 75) begin
      case ($urandom_range(0, 6))
        0:       bad = CH_PLUS;
        1:       bad = CH_MINUS;
        2:       bad = CH_DOT;
        3:       bad = CH_COMMA;
        4:       bad = CH_UNDER;
        5:       bad = SPACE_CHAR;
        default: bad = 8'($urandom_range(0, 255));
      endcase
      pos = $urandom_range(0, text_buf.size());
      text_buf.insert(pos, bad);
    end
  endtask

  // result side: check, random stall bursts, one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (char_valid && !char_stall) chars_seen++;
      if (res_valid && !res_stall) begin
        if (parsed_numbers.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: value %0d ok %0b", $time, res_word.value,
                   res_word.ok);
        end else begin
          want = parsed_numbers.pop_front();
          if (res_word.value !== want.value) begin
            errors++;
            $display("%0t: value mismatch: expected %0d actual %0d", $time, want.value,
                     res_word.value);
          end
          if (res_word.ok !== want.ok) begin
            errors++;
            $display("%0t: ok mismatch: expected %0b actual %0b", $time, want.ok,
                     res_word.ok);
          end
        end
      end
      if (!hold_done && chars_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 12);
      res_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    out_word_t typed_res;
    string     row_text;
    int        rand_chars;
    bit        paused;
    rand_chars = 0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_table[r]) begin
      row_text = dir_table[r].text;
      text_buf.delete();
      for (int k = 0; k < row_text.len(); k++) add_char(row_text[k]);
      typed_res.value = dir_table[r].value;
      typed_res.ok = dir_table[r].ok;
      send_text(dir_table[r].typed, typed_res);
    end
    while (rand_chars < RAND_CHARS) begin
      if (!paused && rand_chars >= PAUSE_AT) begin
        // let every pending word drain before going on
        paused = 1'b1;
        char_valid <= 1'b0;
        do @(posedge clk); while (parsed_numbers.size() != 0);
      end
      if (rand_chars >= CALM_AT) idle_on <= 1'b0;
      make_text();
      send_text(1'b0, '0);
      rand_chars += text_buf.size();
    end
    char_valid <= 1'b0;
    do @(posedge clk); while (parsed_numbers.size() != 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
